FILE: sv/tbgd_pkg.sv
// Shared types and constants of the two-button gesture detector.
// Depends on nothing; imported by tbgd_key and two_button_gesture_detector.
package tbgd_pkg;

  localparam int unsigned TimeBits = 48;
  localparam int unsigned DbW      = 4;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned LimW     = 26;
  localparam int unsigned UsPerMs  = 1000;

  localparam logic [1:0] CfgDebounce  = 2'd0;
  localparam logic [1:0] CfgLongPress = 2'd1;
  localparam logic [1:0] CfgDblClick  = 2'd2;

  localparam logic [DbW-1:0]  DebounceRst = DbW'(2);
  localparam logic [LimW-1:0] LongUsRst   = LimW'(900 * UsPerMs);
  localparam logic [LimW-1:0] DblLimRst   = LimW'(360 * UsPerMs + UsPerMs - 1);

  typedef enum logic [2:0] {
    GestNone     = 3'd0,
    GestAShort   = 3'd1,
    GestADouble  = 3'd2,
    GestALong    = 3'd3,
    GestBShort   = 3'd4,
    GestBDouble  = 3'd5,
    GestBLong    = 3'd6,
    GestChord    = 3'd7
  } gesture_e;

  typedef struct packed {
    logic level;
    logic rose;
    logic fell;
  } key_t;

endpackage

FILE: sv/tbgd_key.sv
// Debounce of one key: debounced level, disagree counter and press time.
// Depends on tbgd_pkg.
module tbgd_key (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          raw_i,
  input  logic [tbgd_pkg::DbW-1:0]      count_i,
  input  logic [tbgd_pkg::TimeBits-1:0] now_i,
  output tbgd_pkg::key_t                key_o,
  output logic [tbgd_pkg::TimeBits-1:0] press_time_o
);
  import tbgd_pkg::*;

  logic                level_q, level_d;
  logic [DbW-1:0]      agree_q, agree_d, agree_inc;
  logic [TimeBits-1:0] ptime_q, ptime_d;

  assign agree_inc = agree_q + DbW'(1);

  always_comb begin
    level_d = level_q;
    agree_d = agree_q;
    ptime_d = ptime_q;
    key_o   = '0;
    if (raw_i == level_q) begin
      agree_d = '0;
    end else if (agree_inc < count_i) begin
      agree_d = agree_inc;
    end else begin
      agree_d    = '0;
      level_d    = raw_i;
      key_o.rose = raw_i;
      key_o.fell = !raw_i;
      if (raw_i) begin
        ptime_d = now_i;
      end
    end
    key_o.level = level_d;
  end

  assign press_time_o = ptime_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      agree_q <= '0;
      ptime_q <= '0;
    end else if (en_i) begin
      level_q <= level_d;
      agree_q <= agree_d;
      ptime_q <= ptime_d;
    end
  end

endmodule

FILE: sv/two_button_gesture_detector.sv
// Top level of the two-button gesture detector: config, gesture logic, output skid.
// Depends on tbgd_pkg and tbgd_key.
//
// Usage:
//   Each request on the input channel (in_valid_i, in_stall_o) is one poll:
//   raw pressed levels of keys A and B plus a microsecond timestamp. Every
//   accepted poll yields exactly one request on the output channel
//   (out_valid_o, out_stall_i) carrying a gesture code, 0 when nothing happened.
//   All state is updated in the accept cycle; the result is registered in the
//   output register (or skid register); while in_stall_o is low, one poll is taken
//   every cycle. Thresholds in microseconds are formed at config write time by
//   a 16x10 bit multiply, so each time check is one 48 bit subtract and compare.
//   When the receiver stalls, one more result is held in a skid register while
//   the output register waits; only with both full does in_stall_o rise.
//   Config writes (cfg_valid_i, cfg_ready_o, always ready) take effect at once;
//   the user must make them while no poll is in flight (not enforced); index
//   3 is ignored. Reset clears all key state and loads debounce 2, long press
//   900 ms and double click 360 ms; both output stages come up empty.
module two_button_gesture_detector (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          pressed_a_i,
  input  logic                          pressed_b_i,
  input  logic [tbgd_pkg::TimeBits-1:0] now_us_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    gesture_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [tbgd_pkg::CfgW-1:0]     cfg_data_i
);
  import tbgd_pkg::*;

  // config
  logic [DbW-1:0]  debounce_q;
  logic [LimW-1:0] long_us_q, dbl_lim_q;
  logic            cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DebounceRst;
      long_us_q  <= LongUsRst;
      dbl_lim_q  <= DblLimRst;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        CfgDebounce:  debounce_q <= cfg_data_i[DbW-1:0];
        CfgLongPress: long_us_q  <= LimW'(cfg_data_i) * LimW'(UsPerMs);
        CfgDblClick:  dbl_lim_q  <= LimW'(cfg_data_i) * LimW'(UsPerMs)
                                    + LimW'(UsPerMs - 1);
        default: ;
      endcase
    end
  end

  // input side
  logic acc;
  assign acc = in_valid_i && !in_stall_o;

  key_t                ka, kb;
  logic [TimeBits-1:0] pa_n, pb_n;

  tbgd_key u_key_a (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (acc),
    .raw_i        (pressed_a_i),
    .count_i      (debounce_q),
    .now_i        (now_us_i),
    .key_o        (ka),
    .press_time_o (pa_n)
  );

  tbgd_key u_key_b (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (acc),
    .raw_i        (pressed_b_i),
    .count_i      (debounce_q),
    .now_i        (now_us_i),
    .key_o        (kb),
    .press_time_o (pb_n)
  );

  // gesture state
  logic                long_done_a_q, long_done_a_d, long_done_b_q, long_done_b_d;
  logic                muted_a_q, muted_a_d, muted_b_q, muted_b_d;
  logic                chord_done_q, chord_done_d;
  logic                wait_a_q, wait_a_d, wait_b_q, wait_b_d;
  logic [TimeBits-1:0] ctime_a_q, ctime_a_d, ctime_b_q, ctime_b_d;

  logic [TimeBits-1:0] diff_pa, diff_pb, diff_ca, diff_cb;
  logic                a_later, chord_hit, long_a_hit, long_b_hit, in_win_a, in_win_b;
  logic                ld_a_n, ld_b_n, mu_a_n, mu_b_n, short_a, short_b;
  gesture_e            gest;

  assign diff_pa = now_us_i - pa_n;
  assign diff_pb = now_us_i - pb_n;
  assign diff_ca = now_us_i - ctime_a_q;
  assign diff_cb = now_us_i - ctime_b_q;

  assign a_later    = pa_n > pb_n;
  assign long_a_hit = diff_pa >= TimeBits'(long_us_q);
  assign long_b_hit = diff_pb >= TimeBits'(long_us_q);
  assign chord_hit  = a_later ? long_a_hit : long_b_hit;
  assign in_win_a   = diff_ca <= TimeBits'(dbl_lim_q);
  assign in_win_b   = diff_cb <= TimeBits'(dbl_lim_q);

  assign ld_a_n  = ka.rose ? 1'b0 : long_done_a_q;
  assign ld_b_n  = kb.rose ? 1'b0 : long_done_b_q;
  assign mu_a_n  = ka.rose ? 1'b0 : muted_a_q;
  assign mu_b_n  = kb.rose ? 1'b0 : muted_b_q;
  assign short_a = ka.fell && !long_done_a_q && !muted_a_q;
  assign short_b = kb.fell && !long_done_b_q && !muted_b_q;

  always_comb begin : p_poll
    logic done;
    done          = 1'b0;
    long_done_a_d = ld_a_n;
    long_done_b_d = ld_b_n;
    muted_a_d     = mu_a_n;
    muted_b_d     = mu_b_n;
    chord_done_d  = chord_done_q;
    wait_a_d      = wait_a_q;
    wait_b_d      = wait_b_q;
    ctime_a_d     = ctime_a_q;
    ctime_b_d     = ctime_b_q;
    gest          = GestNone;
    if (ka.level && kb.level) begin
      wait_a_d  = 1'b0;
      wait_b_d  = 1'b0;
      muted_a_d = 1'b1;
      muted_b_d = 1'b1;
      if (!chord_done_q && chord_hit) begin
        chord_done_d = 1'b1;
        gest         = GestChord;
      end
    end else begin
      if (!ka.level && !kb.level) begin
        chord_done_d = 1'b0;
      end
      if (short_a) begin
        if (wait_a_q && in_win_a) begin
          wait_a_d = 1'b0;
          gest     = GestADouble;
          done     = 1'b1;
        end else if (wait_a_q) begin
          ctime_a_d = now_us_i;
          gest      = GestAShort;
          done      = 1'b1;
        end else begin
          wait_a_d  = 1'b1;
          ctime_a_d = now_us_i;
        end
      end
      if (!done && short_b) begin
        if (wait_b_q && in_win_b) begin
          wait_b_d = 1'b0;
          gest     = GestBDouble;
          done     = 1'b1;
        end else begin
          wait_b_d  = 1'b1;
          ctime_b_d = now_us_i;
        end
      end
      if (!done) begin
        if (ka.level && !ld_a_n && !mu_a_n && long_a_hit) begin
          wait_a_d      = 1'b0;
          long_done_a_d = 1'b1;
          gest          = GestALong;
        end else if (kb.level && !ld_b_n && !mu_b_n && long_b_hit) begin
          wait_b_d      = 1'b0;
          long_done_b_d = 1'b1;
          gest          = GestBLong;
        end else if (wait_a_q && !short_a && !ka.level && !in_win_a) begin
          wait_a_d = 1'b0;
          gest     = GestAShort;
        end else if (wait_b_q && !short_b && !kb.level && !in_win_b) begin
          wait_b_d = 1'b0;
          gest     = GestBShort;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_done_a_q <= 1'b0;
      long_done_b_q <= 1'b0;
      muted_a_q     <= 1'b0;
      muted_b_q     <= 1'b0;
      chord_done_q  <= 1'b0;
      wait_a_q      <= 1'b0;
      wait_b_q      <= 1'b0;
      ctime_a_q     <= '0;
      ctime_b_q     <= '0;
    end else if (acc) begin
      long_done_a_q <= long_done_a_d;
      long_done_b_q <= long_done_b_d;
      muted_a_q     <= muted_a_d;
      muted_b_q     <= muted_b_d;
      chord_done_q  <= chord_done_d;
      wait_a_q      <= wait_a_d;
      wait_b_q      <= wait_b_d;
      ctime_a_q     <= ctime_a_d;
      ctime_b_q     <= ctime_b_d;
    end
  end

  // output register with skid
  logic     out_v_q, skid_v_q, out_take;
  gesture_e out_q, skid_q;

  assign out_take    = out_v_q && !out_stall_i;
  assign in_stall_o  = skid_v_q;
  assign out_valid_o = out_v_q;
  assign gesture_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (out_take) begin
        skid_v_q <= 1'b0;
      end
    end else if (acc) begin
      if (out_v_q && !out_take) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (out_take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (acc) begin
      if (out_v_q && !out_take) begin
        skid_q <= gest;
      end else begin
        out_q <= gest;
      end
    end
  end

  // checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a request while output register is empty");

  a_chord_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && gest == GestChord) |=> chord_done_q && muted_a_q && muted_b_q)
    else $error("chord event did not latch chord state");

  a_long_a_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && gest == GestALong) |=> long_done_a_q && !wait_a_q)
    else $error("key A long press did not latch its done flag");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_v_q)
    else $error("accepted poll left no result");

endmodule

FILE: dv/tb_two_button_gesture_detector.sv
// Self-checking testbench for two_button_gesture_detector: drives polls and register writes,
// predicts one gesture per accepted poll and checks every result against it.
// Depends on tbgd_pkg and the two_button_gesture_detector RTL.
module tb_two_button_gesture_detector;
  timeunit 1ns;
  timeprecision 1ps;

  import tbgd_pkg::*;

  localparam logic [1:0] CfgSpare   = 2'd3;
  localparam int         CycleLimit = 150000;
  localparam int         HoldCycles = 80;

  typedef struct {
    bit              level;
    bit [DbW-1:0]    agree;
    bit [TimeBits-1:0] press_t;
    bit              long_done;
    bit              muted;
    bit              click_wait;
    bit [TimeBits-1:0] click_t;
  } key_model_t;

  class gesture_scoreboard;
    bit [DbW-1:0]  debounce_n;
    bit [CfgW-1:0] long_ms;
    bit [CfgW-1:0] dbl_ms;
    key_model_t    key_a;
    key_model_t    key_b;
    bit            chord_done;
    gesture_e      expected_gestures[$];
    int            failures;

    function new();
      debounce_n = 4'd2;
      long_ms    = 16'd900;
      dbl_ms     = 16'd360;
      key_a      = '{default: '0};
      key_b      = '{default: '0};
      chord_done = 1'b0;
      failures   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        CfgDebounce:  debounce_n = data[DbW-1:0];
        CfgLongPress: long_ms = data;
        CfgDblClick:  dbl_ms = data;
        default: ;
      endcase
    endfunction

    function bit [TimeBits-1:0] ms_between(bit [TimeBits-1:0] now, bit [TimeBits-1:0] then);
      return (now - then) / TimeBits'(UsPerMs);
    endfunction

    // Return 1 when the key comes back up from a plain short press.
    function bit settle_key(inout key_model_t k, input bit raw, input bit [TimeBits-1:0] now);
      if (raw == k.level) begin
        k.agree = '0;
        return 1'b0;
      end
      k.agree = k.agree + 1'b1;
      if (k.agree < debounce_n) return 1'b0;
      k.agree = '0;
      k.level = raw;
      if (raw) begin
        k.press_t   = now;
        k.long_done = 1'b0;
        k.muted     = 1'b0;
        return 1'b0;
      end
      return !k.long_done && !k.muted;
    endfunction

    function gesture_e next_gesture(bit raw_a, bit raw_b, bit [TimeBits-1:0] now);
      bit                short_a;
      bit                short_b;
      bit [TimeBits-1:0] start;
      short_a = settle_key(key_a, raw_a, now);
      short_b = settle_key(key_b, raw_b, now);
      if (key_a.level && key_b.level) begin
        start = (key_a.press_t > key_b.press_t) ? key_a.press_t : key_b.press_t;
        key_a.click_wait = 1'b0;
        key_b.click_wait = 1'b0;
        key_a.muted      = 1'b1;
        key_b.muted      = 1'b1;
        if (!chord_done && ms_between(now, start) >= long_ms) begin
          chord_done = 1'b1;
          return GestChord;
        end
        return GestNone;
      end
      if (!key_a.level && !key_b.level) chord_done = 1'b0;
      if (short_a) begin
        if (key_a.click_wait && ms_between(now, key_a.click_t) <= dbl_ms) begin
          key_a.click_wait = 1'b0;
          return GestADouble;
        end
        if (key_a.click_wait) begin
          key_a.click_t = now;
          return GestAShort;
        end
        key_a.click_wait = 1'b1;
        key_a.click_t    = now;
      end
      if (short_b) begin
        if (key_b.click_wait && ms_between(now, key_b.click_t) <= dbl_ms) begin
          key_b.click_wait = 1'b0;
          return GestBDouble;
        end
        key_b.click_wait = 1'b1;
        key_b.click_t    = now;
      end
      if (key_a.level && !key_a.long_done && !key_a.muted &&
          ms_between(now, key_a.press_t) >= long_ms) begin
        key_a.click_wait = 1'b0;
        key_a.long_done  = 1'b1;
        return GestALong;
      end
      if (key_b.level && !key_b.long_done && !key_b.muted &&
          ms_between(now, key_b.press_t) >= long_ms) begin
        key_b.click_wait = 1'b0;
        key_b.long_done  = 1'b1;
        return GestBLong;
      end
      if (key_a.click_wait && !key_a.level && ms_between(now, key_a.click_t) > dbl_ms) begin
        key_a.click_wait = 1'b0;
        return GestAShort;
      end
      if (key_b.click_wait && !key_b.level && ms_between(now, key_b.click_t) > dbl_ms) begin
        key_b.click_wait = 1'b0;
        return GestBShort;
      end
      return GestNone;
    endfunction

    function void note_poll(bit raw_a, bit raw_b, bit [TimeBits-1:0] now);
      expected_gestures.push_back(next_gesture(raw_a, raw_b, now));
    endfunction

    function void check_result(logic [2:0] got);
      gesture_e want;
      if (expected_gestures.size() == 0) begin
        failures++;
        if (failures <= 10) $display("%0t: gesture %0d with no poll outstanding", $time, got);
        return;
      end
      want = expected_gestures.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10)
          $display("%0t: gesture mismatch, expected %s (%0d), got %0d",
                   $time, want.name(), want, got);
      end
    endfunction

    function int pending();
      return expected_gestures.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                pressed_a_i;
  logic                pressed_b_i;
  logic [TimeBits-1:0] now_us_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [2:0]          gesture_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i;
  logic [CfgW-1:0]     cfg_data_i;

  gesture_scoreboard board;
  int                idle_pct;
  int                stall_pct;
  bit                hold_req;
  int                hold_left;
  int                cycles;
  int                cur_db;
  bit                raw_a;
  bit                raw_b;
  int                run_a;
  int                run_b;
  logic [TimeBits-1:0] now_t;

  two_button_gesture_detector dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .pressed_a_i (pressed_a_i),
    .pressed_b_i (pressed_b_i),
    .now_us_i    (now_us_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .gesture_o   (gesture_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) board.check_result(gesture_o);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic put_reg(input logic [1:0] idx, input logic [CfgW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
  endtask

  task automatic configure(input logic [CfgW-1:0] db_word, input logic [CfgW-1:0] lp,
                           input logic [CfgW-1:0] dc, input bit with_spare);
    put_reg(CfgDebounce, db_word);
    put_reg(CfgLongPress, lp);
    put_reg(CfgDblClick, dc);
    if (with_spare) put_reg(CfgSpare, CfgW'($urandom));
    cfg_valid_i <= 1'b0;
    cur_db = db_word[DbW-1:0];
  endtask

  task automatic send_poll(input bit a, input bit b, input logic [TimeBits-1:0] t);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    pressed_a_i <= a;
    pressed_b_i <= b;
    now_us_i    <= t;
    do @(posedge clk_i); while (in_stall_o);
    board.note_poll(a, b, t);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  function automatic int run_len();
    int eff;
    int roll;
    eff  = (cur_db == 0) ? 1 : cur_db;
    roll = $urandom_range(99);
    if (roll < 15) return $urandom_range(1, (eff > 1) ? eff - 1 : 1);
    if (roll < 60) return eff + $urandom_range(0, 4);
    if (roll < 90) return eff + $urandom_range(5, 40);
    return eff + $urandom_range(41, 90);
  endfunction

  // Wraps to zero partway through; ends with a timestamp that steps backwards.
  task automatic run_directed();
    logic [TimeBits-1:0] base;
    base = {TimeBits{1'b1}} - TimeBits'(20999);
    send_poll(0, 0, base);
    send_poll(1, 0, base + 1000);
    send_poll(0, 0, base + 2000);
    send_poll(1, 0, base + 3000);
    send_poll(0, 0, base + 4000);
    send_poll(1, 0, base + 5000);
    send_poll(0, 0, base + 6000);
    send_poll(1, 0, base + 10000);
    send_poll(0, 0, base + 11000);
    send_poll(0, 0, base + 20999);
    send_poll(0, 1, base + 21000);
    send_poll(0, 0, base + 22000);
    send_poll(0, 1, base + 23000);
    send_poll(0, 0, base + 26000);
    send_poll(0, 1, base + 27000);
    send_poll(0, 0, base + 28000);
    send_poll(1, 0, base + 30000);
    send_poll(1, 0, base + 35000);
    send_poll(0, 1, base + 40000);
    send_poll(0, 1, base + 46000);
    send_poll(1, 1, base + 50000);
    send_poll(1, 1, base + 55000);
    send_poll(0, 0, base + 56000);
    send_poll(1, 0, base + 57000);
    send_poll(1, 0, base + 50000);
  endtask

  task automatic run_random(input int n, input int step_max, input bit pressure);
    int i;
    now_t = {16'($urandom), $urandom};
    for (i = 0; i < n; i++) begin
      if (run_a <= 0) begin
        raw_a = !raw_a;
        run_a = run_len();
      end
      if (run_b <= 0) begin
        raw_b = !raw_b;
        run_b = run_len();
      end
      run_a--;
      run_b--;
      if ($urandom_range(999) < 4) now_t = {16'($urandom), $urandom};
      else now_t = now_t + TimeBits'($urandom_range(0, step_max));
      if (pressure && i == n / 3) hold_req = 1'b1;
      send_poll(raw_a, raw_b, now_t);
    end
  endtask

  initial begin
    board       = new();
    hold_req    = 1'b0;
    hold_left   = 0;
    cycles      = 0;
    raw_a       = 1'b0;
    raw_b       = 1'b0;
    run_a       = 0;
    run_b       = 0;
    idle_pct    = 25;
    stall_pct   = 50;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    pressed_a_i <= 1'b0;
    pressed_b_i <= 1'b0;
    now_us_i    <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CfgDebounce;
    cfg_data_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(16'hFFF0, 16'd5, 16'd2, 1'b0);
    run_directed();
    settle();

    configure({12'($urandom), 4'd2}, 16'd900, 16'd360, 1'b0);
    run_random(290, 60000, 1'b0);
    settle();
    configure({12'($urandom), 4'd1}, 16'd1, 16'd1, 1'b0);
    run_random(290, 1500, 1'b1);
    settle();

    idle_pct  = 50;
    stall_pct = 25;
    configure({12'($urandom), 4'd15}, 16'hFFFF, 16'hFFFF, 1'b0);
    run_random(290, 5000000, 1'b0);
    settle();
    configure(16'h0000, 16'd0, 16'd0, 1'b1);
    run_random(290, 2500, 1'b0);
    settle();

    idle_pct  = 0;
    stall_pct = 0;
    configure({12'($urandom), 4'd3}, 16'd20, 16'd10, 1'b0);
    run_random(290, 6000, 1'b0);
    settle();
    configure({12'($urandom), 4'($urandom_range(1, 15))}, CfgW'($urandom_range(1, 300)),
              CfgW'($urandom_range(1, 200)), 1'b0);
    run_random(290, 4000, 1'b0);
    settle();

    repeat (4) @(posedge clk_i);
    if (board.pending() == 0 && board.failures == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
